>>> rtl/zbr_pkg.sv
// Shared types and constants for the z-buffered line rasteriser.
package zbr_pkg;

  localparam int COORD_W = 12;
  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 32;
  localparam int COUNT_W = 13;
  localparam int RDPOS_W = 7;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [DEPTH_W-1:0]        start_depth;
    logic [DEPTH_W-1:0]        end_depth;
    logic [COLOR_W-1:0]        line_color;
    logic [RDPOS_W-1:0]        read_col;
    logic [RDPOS_W-1:0]        read_row;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pixels_written;
    logic [COLOR_W-1:0] read_color;
    logic [DEPTH_W-1:0] read_depth;
  } rsp_t;

  // divider handshake
  typedef struct packed {
    logic               start;
    logic               neg;
    logic [27:0]        num;
    logic [COORD_W:0]   den;
  } div_req_t;

endpackage

>>> rtl/zbr_if.sv
// Valid/ready channel interface carrying one payload beat.
interface zbr_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/zbr_div.sv
// Shared restoring divider: one quotient bit per cycle, signed result by magnitude.
module zbr_div
  import zbr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  div_req_t           req,
  output logic               done,
  output logic signed [28:0] quot
);

  localparam int NW = 28;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]      q_r, q_nxt;
  logic [COORD_W:0]   rem_r, rem_nxt;
  logic [COORD_W:0]   den_r;
  logic               neg_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r;
  logic [COORD_W+1:0] trial;

  always_comb begin
    trial = {rem_r, q_r[NW-1]} - {1'b0, den_r};
    if (!trial[COORD_W+1]) begin
      rem_nxt = trial[COORD_W:0];
      q_nxt   = {q_r[NW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[COORD_W-1:0], q_r[NW-1]};
      q_nxt   = {q_r[NW-2:0], 1'b0};
    end
    cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_nxt;
      if (cnt_nxt == '0) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.num;
      rem_r <= '0;
      den_r <= req.den;
      neg_r <= req.neg;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = !busy_r && !req.start;
  assign quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

>>> rtl/zbuffered_line_rasterizer.sv
// Top level: z-buffered Bresenham line rasteriser with depth and colour stores.
// Reset: a clearing pass over every store entry fills the stores; no item
// is accepted until it ends. Read: store read, then the result registered. Draw:
// for each pixel on the line, the shared 28-step divider interpolates depth,
// then store read and depth test/write. One item in flight at a time; the
// result waits in an output register and the next item is taken as it leaves.
module zbuffered_line_rasterizer
  import zbr_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  zbr_if.sink                  in_ch,
  zbr_if.source                out_ch
);

  localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = COORD_W + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_RPEND = 3'd7;

  logic [DEPTH_W-1:0] zmem [DEPTH];
  logic [COLOR_W-1:0] cmem [DEPTH];

  logic [2:0]          state_r;
  logic [CFG_W-1:0]    width_r, height_r;
  logic [AW-1:0]       clr_r;
  logic signed [DW:0]  x_r, y_r, err_r;
  logic signed [DW:0]  x1_r, y1_r, dx_r, dy_r;
  logic                sx_r, sy_r;
  logic [DW-1:0]       tot_r, j_r;
  logic [DEPTH_W-1:0]  z0_r, z_r, zrd_r;
  logic signed [DEPTH_W:0] dz_r;
  logic [COLOR_W-1:0]  col_r, crd_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [AW-1:0]       addr_r;
  logic                inwin_r, rd_ok_r;
  logic                div_kick_r;
  rsp_t                rsp_r;

  div_req_t            dreq;
  logic                ddone;
  logic signed [28:0]  dq;
  logic [27:0]         prod;
  logic signed [DW+1:0] e2;
  logic                last;
  logic signed [DW:0]  xn, yn, errn;
  logic [CFG_W:0]      wlim, hlim;
  req_t                rq;

  assign rq = in_ch.data;
  assign wlim = (width_r  > CFG_W'(MAX_WIDTH  > 255 ? 255 : MAX_WIDTH))
              ? (CFG_W+1)'(MAX_WIDTH  > 255 ? 255 : MAX_WIDTH)  : {1'b0, width_r};
  assign hlim = (height_r > CFG_W'(MAX_HEIGHT > 255 ? 255 : MAX_HEIGHT))
              ? (CFG_W+1)'(MAX_HEIGHT > 255 ? 255 : MAX_HEIGHT) : {1'b0, height_r};

  // |dz| * j fits 16+12 bits
  assign prod = 28'((dz_r < 0 ? -dz_r : dz_r)) * 28'(j_r);
  assign dreq.start = div_kick_r;
  assign dreq.neg   = dz_r < 0;
  assign dreq.num   = prod;
  assign dreq.den   = tot_r;

  zbr_div u_div (.clk, .rst_n, .req(dreq), .done(ddone), .quot(dq));

  assign last = (x_r == x1_r) && (y_r == y1_r);
  always_comb begin
    e2   = {err_r, 1'b0};
    xn   = x_r;
    yn   = y_r;
    errn = err_r;
    if (e2 > -(DW+2)'(dy_r)) begin
      errn = errn - dy_r;
      xn   = sx_r ? x_r + (DW+1)'(1) : x_r - (DW+1)'(1);
    end
    if (e2 < (DW+2)'(dx_r)) begin
      errn = errn + dx_r;
      yn   = sy_r ? y_r + (DW+1)'(1) : y_r - (DW+1)'(1);
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE) || (state_r == S_OUT && out_ch.ready);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      zmem[clr_r] <= '1;
      cmem[clr_r] <= '0;
    end else if (state_r == S_TEST && inwin_r && z_r < zrd_r) begin
      zmem[addr_r] <= z_r;
      cmem[addr_r] <= col_r;
    end
    zrd_r <= zmem[addr_r];
    crd_r <= cmem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      div_kick_r <= 1'b0;
    end else begin
      div_kick_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE, S_OUT: begin
          if (in_ch.valid && in_ch.ready) begin
            if (rq.req_type == REQ_READ) begin
              state_r <= S_RPEND;
            end else begin
              state_r    <= S_DIV;
              div_kick_r <= 1'b1;
            end
          end else if (state_r == S_OUT && out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        S_DIV: if (!div_kick_r && ddone) state_r <= S_RD;
        S_RD:   state_r <= S_TEST;
        S_TEST: begin
          if (last) begin
            state_r <= S_OUT;
          end else begin
            state_r    <= S_DIV;
            div_kick_r <= 1'b1;
          end
        end
        S_RPEND: state_r <= S_READ;
        S_READ: state_r <= S_OUT;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE, S_OUT: begin
        if (in_ch.valid && in_ch.ready) begin
          x_r   <= (DW+1)'(rq.start_x);
          y_r   <= (DW+1)'(rq.start_y);
          x1_r  <= (DW+1)'(rq.end_x);
          y1_r  <= (DW+1)'(rq.end_y);
          sx_r  <= rq.start_x < rq.end_x;
          sy_r  <= rq.start_y < rq.end_y;
          begin : setup
            logic signed [DW:0] ddx, ddy;
            ddx = (DW+1)'(rq.end_x) - (DW+1)'(rq.start_x);
            ddy = (DW+1)'(rq.end_y) - (DW+1)'(rq.start_y);
            ddx = ddx < 0 ? -ddx : ddx;
            ddy = ddy < 0 ? -ddy : ddy;
            dx_r  <= ddx;
            dy_r  <= ddy;
            err_r <= ddx - ddy;
            tot_r <= (ddx > ddy) ? ddx[DW-1:0] : ddy[DW-1:0];
          end
          j_r   <= '0;
          z0_r  <= rq.start_depth;
          dz_r  <= $signed({1'b0, rq.end_depth}) - $signed({1'b0, rq.start_depth});
          col_r <= rq.line_color;
          cnt_r <= '0;
          rd_ok_r <= (32'(rq.read_col) < 32'(MAX_WIDTH)) && (32'(rq.read_row) < 32'(MAX_HEIGHT));
          addr_r  <= AW'(32'(rq.read_row) * 32'(MAX_WIDTH) + 32'(rq.read_col));
        end
      end
      S_DIV: begin
        z_r     <= (tot_r == '0) ? z0_r : DEPTH_W'(29'(z0_r) + dq);
        inwin_r <= (x_r >= 0) && (y_r >= 0) &&
                   (x_r < (DW+1)'(wlim)) && (y_r < (DW+1)'(hlim));
        addr_r  <= AW'(32'(y_r[DW-1:0]) * 32'(MAX_WIDTH) + 32'(x_r[DW-1:0]));
      end
      S_TEST: begin
        if (inwin_r && z_r < zrd_r) cnt_r <= cnt_r + COUNT_W'(1);
        x_r   <= xn;
        y_r   <= yn;
        err_r <= errn;
        j_r   <= j_r + DW'(1);
      end
      default: ;
    endcase
    if (state_r == S_READ) begin
      rsp_r.pixels_written <= '0;
      rsp_r.read_color     <= rd_ok_r ? crd_r : '0;
      rsp_r.read_depth     <= rd_ok_r ? zrd_r : '0;
    end else if (state_r == S_TEST && last) begin
      rsp_r.pixels_written <= (inwin_r && z_r < zrd_r) ? cnt_r + COUNT_W'(1) : cnt_r;
      rsp_r.read_color     <= '0;
      rsp_r.read_depth     <= '0;
    end
  end

endmodule
